// ===== hdl/csd_pkg.sv =====
// shared types and constants for the cross stencil star detector
`timescale 1ns / 1ps

package csd_pkg;

   // default line store and frame limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // fixed field widths
   localparam int PIXEL_W = 8;
   localparam int CSR_W   = 11;
   localparam int ROW_W   = 10;
   localparam int COL_W   = 10;
   localparam int SUM_W   = 11;
   localparam int TOTAL_W = 21;

   // register reset values and the minimum frame size
   localparam int WIDTH_RESET     = 8;
   localparam int HEIGHT_RESET    = 6;
   localparam int THRESHOLD_RESET = 30;
   localparam int MIN_SIZE        = 3;

   // event queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [TOTAL_W-1:0] STAR_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_SUM_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_STAR    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   // one queued event: a star or an end-of-frame summary
   typedef struct packed {
      kind_type          kind;
      logic              clear;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [SUM_W-1:0]  sum;
   } event_type;

endpackage

// ===== hdl/cross_stencil_star_detector.sv =====
// top level of the cross stencil star detector: registers, front, queue and back
`timescale 1ns / 1ps
// a result is registered in the event queue and then in the result register
// throughput: one pixel per cycle unless the queue is full, set by the prefetched reads
// the line store has two prefetch read ports so every window is ready at acceptance
// reset (synchronous, active high) clears counters, queue and count; registers return
// to width 8, height 6, threshold 30; the line stores are not cleared

module cross_stencil_star_detector #(
   parameter int MAX_WIDTH  = csd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = csd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel transactions
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csd_pkg::PIXEL_W-1:0]   req_pixel,
   input  logic                          req_frame_start,
   // result transactions
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic [csd_pkg::ROW_W-1:0]     rsp_star_row,
   output logic [csd_pkg::COL_W-1:0]     rsp_star_col,
   output logic [csd_pkg::SUM_W-1:0]     rsp_cross_sum,
   output logic [csd_pkg::TOTAL_W-1:0]   rsp_star_total,
   // register writes
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [csd_pkg::CSR_W-1:0]     csr_wdata
);
   import csd_pkg::*;

   localparam int WCW = $clog2(MAX_WIDTH) + 1;
   localparam int HCW = $clog2(MAX_HEIGHT) + 1;

   // sizes are held already saturated into their legal range
   logic [WCW-1:0]   width_ff;
   logic [HCW-1:0]   height_ff;
   logic [SUM_W-1:0] threshold_ff;
   logic [WCW-1:0]   width_clamped;
   logic [HCW-1:0]   height_clamped;

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_head_valid;
   event_type q_entry;
   event_type q_head;

   always_comb begin
      if (csr_wdata < CSR_W'(MIN_SIZE)) begin
         width_clamped = WCW'(MIN_SIZE);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         width_clamped = WCW'(MAX_WIDTH);
      end else begin
         width_clamped = WCW'(csr_wdata);
      end
      if (csr_wdata < CSR_W'(MIN_SIZE)) begin
         height_clamped = HCW'(MIN_SIZE);
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         height_clamped = HCW'(MAX_HEIGHT);
      end else begin
         height_clamped = HCW'(csr_wdata);
      end
   end

   // register file; writes to an unused index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WCW'(WIDTH_RESET);
         height_ff    <= HCW'(HEIGHT_RESET);
         threshold_ff <= SUM_W'(THRESHOLD_RESET);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   width_ff     <= width_clamped;
            CSR_FRAME_HEIGHT:  height_ff    <= height_clamped;
            CSR_SUM_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: counters, line store and star / summary classification
   csd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .cfg_threshold   (threshold_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   // decouples classification from result delivery
   csd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   // back: star count per frame and the result register
   csd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_entry      (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_star_row    (rsp_star_row),
      .rsp_star_col    (rsp_star_col),
      .rsp_cross_sum   (rsp_cross_sum),
      .rsp_star_total  (rsp_star_total)
   );

endmodule

// ===== hdl/csd_front.sv =====
// front end: pixel acceptance, raster counters, line store and cross sum classification
`timescale 1ns / 1ps

module csd_front #(
   parameter int MAX_WIDTH  = csd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = csd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [csd_pkg::PIXEL_W-1:0]          req_pixel,
   input  logic                                 req_frame_start,
   input  logic [$clog2(MAX_WIDTH):0]           cfg_width,
   input  logic [$clog2(MAX_HEIGHT):0]          cfg_height,
   input  logic [csd_pkg::SUM_W-1:0]            cfg_threshold,
   input  logic                                 q_full,
   output logic                                 q_push,
   output csd_pkg::event_type                   q_entry
);
   import csd_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WCW = WW + 1;
   localparam int HCW = RW + 1;

   // each word holds {row above, row two above} for one column
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_W-1:0] rd0_ff;
   logic [2*PIXEL_W-1:0] rd1_ff;
   logic [WW-1:0]        rd1_addr;

   logic [WW-1:0]      col_ff, col_in, col_cur;
   logic [RW-1:0]      row_ff, row_in, row_cur;
   logic               clear_pend_ff, clear_pend_in;
   logic [PIXEL_W-1:0] prev_above_ff;

   logic             accept;
   logic             first_px;
   logic             row_end;
   logic             frame_end;
   logic             cross_ok;
   logic             star;
   logic [SUM_W-1:0] sum;
   logic [WCW-1:0]   col_ext;
   logic [HCW-1:0]   row_ext;

   always_comb begin
      accept   = req_valid && !q_full;
      col_cur  = req_frame_start ? '0 : col_ff;
      row_cur  = req_frame_start ? '0 : row_ff;
      col_ext  = {1'b0, col_cur};
      row_ext  = {1'b0, row_cur};
      first_px = (row_cur == '0) && (col_cur == '0);

      row_end   = (col_ext + WCW'(1)) >= cfg_width;
      frame_end = row_end && ((row_ext + HCW'(1)) >= cfg_height);
      cross_ok  = (row_cur >= RW'(2)) && (col_cur != '0)
                  && ((col_ext + WCW'(2)) <= cfg_width);

      // centre, up, left, right, down
      sum = SUM_W'(rd0_ff[2*PIXEL_W-1:PIXEL_W]) + SUM_W'(rd0_ff[PIXEL_W-1:0])
            + SUM_W'(prev_above_ff) + SUM_W'(rd1_ff[2*PIXEL_W-1:PIXEL_W])
            + SUM_W'(req_pixel);
      star = cross_ok && (sum > cfg_threshold);

      q_push        = accept && (star || frame_end);
      q_entry.kind  = frame_end ? KIND_SUMMARY : KIND_STAR;
      q_entry.clear = clear_pend_ff || first_px;
      q_entry.row   = frame_end ? '0 : ROW_W'(row_cur - RW'(1));
      q_entry.col   = frame_end ? '0 : COL_W'(col_cur);
      q_entry.sum   = frame_end ? '0 : sum;

      col_in        = col_ff;
      row_in        = row_ff;
      clear_pend_in = clear_pend_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_cur + RW'(1);
         end else begin
            col_in = col_cur + WW'(1);
            row_in = row_cur;
         end
         if (q_push) begin
            clear_pend_in = 1'b0;
         end else if (first_px) begin
            clear_pend_in = 1'b1;
         end
      end
      rd1_addr  = col_in + WW'(1);
      req_stall = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         clear_pend_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

   // line store: prefetch this column and the next, shift on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_cur] <= {req_pixel, rd0_ff[2*PIXEL_W-1:PIXEL_W]};
         prev_above_ff     <= rd0_ff[2*PIXEL_W-1:PIXEL_W];
      end
      rd0_ff <= line_mem[col_in];
      rd1_ff <= line_mem[rd1_addr];
   end

   a_star_not_at_row_end: assert property (@(posedge clock) disable iff (reset)
      !(accept && star && row_end))
      else $error("star flagged on a row end column");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters did not wrap after frame end");

endmodule

// ===== hdl/csd_queue.sv =====
// short event queue between the front and back ends
`timescale 1ns / 1ps

module csd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csd_pkg::event_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output csd_pkg::event_type  head_entry
);
   import csd_pkg::*;

   event_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("event pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("event popped from an empty queue");

endmodule

// ===== hdl/csd_back.sv =====
// back end: star counting and the registered result stage
`timescale 1ns / 1ps

module csd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  csd_pkg::event_type            head_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_result_kind,
   output logic [csd_pkg::ROW_W-1:0]     rsp_star_row,
   output logic [csd_pkg::COL_W-1:0]     rsp_star_col,
   output logic [csd_pkg::SUM_W-1:0]     rsp_cross_sum,
   output logic [csd_pkg::TOTAL_W-1:0]   rsp_star_total
);
   import csd_pkg::*;

   logic               valid_ff;
   logic [TOTAL_W-1:0] count_ff, count_in;
   logic [TOTAL_W-1:0] base;
   kind_type           kind_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TOTAL_W-1:0] total_ff;

   always_comb begin
      pop  = head_valid && (!valid_ff || !rsp_stall);
      base = head_entry.clear ? '0 : count_ff;
      if (head_entry.kind == KIND_STAR) begin
         count_in = (base == STAR_MAX) ? base : base + TOTAL_W'(1);
      end else begin
         count_in = base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            count_ff <= count_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= head_entry.kind;
         row_ff   <= head_entry.row;
         col_ff   <= head_entry.col;
         sum_ff   <= head_entry.sum;
         total_ff <= count_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_star_row    = row_ff;
   assign rsp_star_col    = col_ff;
   assign rsp_cross_sum   = sum_ff;
   assign rsp_star_total  = total_ff;

   a_count_tracks_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> (total_ff == count_ff))
      else $error("reported total differs from running count");

endmodule
